// ----- rtl/cobsc_pkg.sv -----
package cobsc_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CapW   = 16;
    localparam int unsigned CountW = 17;
    localparam int unsigned CrcW   = 32;

    localparam logic [CrcW-1:0]   CrcPoly     = 32'hEDB8_8320;
    localparam logic [ByteW-1:0]  NoZeroCode  = 8'hFF;
    localparam logic [CapW-1:0]   CapReset    = 16'd255;
    localparam logic [CountW-1:0] CrcBytes    = 17'd4;

    typedef struct packed {
        logic              byte_valid;
        logic [ByteW-1:0]  out_byte;
        logic              frame_done;
        logic              frame_good;
        logic [CapW-1:0]   payload_length;
    } t_result;

endpackage

// ----- rtl/cobs_crc32_frame_decoder_unit.sv -----
// COBS frame decoder with CRC-32 check.
// The slave stream takes one encoded byte per transfer in s_axis_tdata[7:0].
// The master stream gives one result per decoded byte and per closing zero:
// m_axis_tuser is set when m_axis_tdata[7:0] carries a decoded byte,
// m_axis_tlast marks the transfer that closes the frame, and on that transfer
// m_axis_tdata[8] tells a good frame (CRC residue zero, at least four bytes)
// and m_axis_tdata[24:9] the payload length without the four CRC bytes.
// A code byte that follows a 0xFF code gives no result at all.
// The user must write the capacity register through i_cfg_we/i_cfg_wdata
// only while the block is idle; the block itself does not enforce this. A
// frame that decodes more bytes than capacity is closed. Each input byte
// passes the input register, then the decode and CRC step into the result
// register. While the receiver keeps up, one byte is taken every cycle, set by
// the byte-wide CRC step. When the receiver stalls, the result register
// holds and the input register fills, after which s_axis_tready drops until
// the result is taken. Reset clears the frame state and sets capacity to 255.
module cobs_crc32_frame_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [8] frame_good,
                                        // [24:9] payload_length, [31:25] zero
    output logic        m_axis_tuser,   // [0] byte_valid
    output logic        m_axis_tlast    // frame_done
);
    import cobsc_pkg::*;

    logic    out_free;
    logic    load;
    t_result dec_result;
    t_result out_result;

    cobsc_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_out_free    (out_free),
        .o_load        (load),
        .o_result      (dec_result)
    );

    cobsc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_result (dec_result),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    assign m_axis_tdata = {7'd0, out_result.payload_length, out_result.frame_good,
                           out_result.out_byte};
    assign m_axis_tuser = out_result.byte_valid;
    assign m_axis_tlast = out_result.frame_done;

endmodule

// ----- rtl/cobsc_decode.sv -----
module cobsc_decode (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [15:0]             i_cfg_wdata,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [7:0]              s_axis_tdata,
    input  logic                    i_out_free,
    output logic                    o_load,
    output cobsc_pkg::t_result      o_result
);
    import cobsc_pkg::*;

    function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
        logic [CrcW-1:0] c;
        c = crc ^ {{(CrcW-ByteW){1'b0}}, b};
        for (int k = 0; k < ByteW; k++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

    logic [CapW-1:0]   r_capacity;
    logic              r_in_valid;
    logic [ByteW-1:0]  r_in_byte;
    logic [ByteW-1:0]  r_bytes_left, n_bytes_left;
    logic [ByteW-1:0]  r_last_code, n_last_code;
    logic [CountW-1:0] r_count, n_count;
    logic [CrcW-1:0]   r_crc, n_crc;

    logic              adv, has_left, is_zero, ins_zero, emit, ovf, close, produce, good;
    logic [ByteW-1:0]  emit_val;
    logic [CrcW-1:0]   crc_new, res_crc;
    logic [CountW-1:0] cnt_new, res_cnt, len_full;

    assign adv           = r_in_valid && i_out_free;
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CapReset;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // A data byte is decoded while a block is open, or as the implied zero
    // that a new code byte inserts unless the previous code was 0xFF.
    always_comb begin
        has_left = (r_bytes_left != '0);
        is_zero  = (r_in_byte == '0);
        ins_zero = (r_last_code != NoZeroCode);
        emit     = has_left || (!is_zero && ins_zero);
        emit_val = has_left ? r_in_byte : '0;
        crc_new  = crc_byte(r_crc, emit_val);
        cnt_new  = r_count + 1'b1;
        ovf      = emit && (cnt_new > {1'b0, r_capacity});
        close    = ovf || (!has_left && is_zero);
        produce  = emit || close;
        res_crc  = emit ? crc_new : r_crc;
        res_cnt  = emit ? cnt_new : r_count;
        good     = close && (res_crc == '0) && (res_cnt >= CrcBytes);
        len_full = res_cnt - CrcBytes;

        o_result.byte_valid     = emit;
        o_result.out_byte       = emit_val;
        o_result.frame_done     = close;
        o_result.frame_good     = good;
        o_result.payload_length = good ? len_full[CapW-1:0] : '0;
    end

    assign o_load = adv && produce;

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_last_code  = r_last_code;
        n_count      = res_cnt;
        n_crc        = res_crc;
        if (close) begin
            n_bytes_left = '0;
            n_last_code  = NoZeroCode;
            n_count      = '0;
            n_crc        = '0;
        end else if (has_left) begin
            n_bytes_left = r_bytes_left - 1'b1;
        end else begin
            n_last_code  = r_in_byte;
            n_bytes_left = r_in_byte - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_last_code  <= NoZeroCode;
            r_count      <= '0;
            r_crc        <= '0;
        end else if (adv) begin
            r_bytes_left <= n_bytes_left;
            r_last_code  <= n_last_code;
            r_count      <= n_count;
            r_crc        <= n_crc;
        end
    end

`ifndef SYNTHESIS
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && close |=> (r_count == '0) && (r_crc == '0) && (r_bytes_left == '0)
                         && (r_last_code == NoZeroCode))
        else $error("frame state not cleared after frame end");

    a_left_below_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bytes_left != '0) |-> (r_bytes_left < r_last_code))
        else $error("pending byte count exceeds its code byte");

    a_empty_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_crc == '0))
        else $error("CRC residue nonzero with no decoded bytes");

    a_no_byte_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load && !o_result.byte_valid |-> o_result.frame_done)
        else $error("result without a byte does not close the frame");
`endif

endmodule

// ----- rtl/cobsc_out_reg.sv -----
module cobsc_out_reg (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  cobsc_pkg::t_result      i_result,
    output logic                    o_free,
    output logic                    o_valid,
    input  logic                    i_ready,
    output cobsc_pkg::t_result      o_result
);
    import cobsc_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule
